/* hw/rtl/rwh_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers for the rolling window hash
package rwh_pkg;

  // default sizing handed to the top level
  localparam int unsigned WINDOW_MAX_DEF   = 64;
  localparam int unsigned POSITION_MAX_DEF = 65535;

  // field widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned WS_W   = 7;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned HASH_W = 33;
  localparam int unsigned BASE_W = 7;
  localparam int unsigned PW_W   = HASH_W + BASE_W;

  // reduction accumulator and radix-4 digit sequencing
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned DIGITS  = 8;
  localparam int unsigned DIGIT_W = 3;

  localparam logic [HASH_W-1:0] HASH_MOD     = 33'd5463458053;
  localparam logic [BASE_W-1:0] HASH_BASE    = 7'd101;
  localparam logic [WS_W-1:0]   RESET_WINDOW = 7'd5;

  // bias that keeps the roll-out subtraction non-negative: base * 255 * modulus
  localparam int unsigned       DROP_SPAN   = 32'(HASH_BASE) * ((1 << CHAR_W) - 1);
  localparam logic [ACC_W-1:0]  DROP_OFFSET = ACC_W'(HASH_MOD) * ACC_W'(DROP_SPAN);

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              first_of_string;
  } rwh_in_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic [POS_W-1:0]  window_start;
  } rwh_out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_SUM,
    OP_REDUCE,
    OP_UPDATE,
    OP_CFG,
    OP_POW,
    OP_POW_WB
  } rwh_op_e;

  typedef struct packed {
    rwh_op_e              op;
    logic [DIGIT_W-1:0]   digit;
  } rwh_cmd_t;

  typedef struct packed {
    logic emit;
    logic pow_done;
    logic pow_last;
  } rwh_status_t;

  // d * modulus * 4^j, only ever called with constant arguments
  function automatic logic [ACC_W-1:0] mod_multiple(int unsigned d, int unsigned j);
    logic [ACC_W-1:0] m;
    m = ACC_W'(HASH_MOD) * ACC_W'(d);
    return m << (2 * j);
  endfunction

  // base^n mod modulus, evaluated at elaboration for reset values
  function automatic logic [HASH_W-1:0] base_power(int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = (p * 64'(HASH_BASE)) % 64'(HASH_MOD);
    end
    return HASH_W'(p);
  endfunction

endpackage

/* hw/rtl/rolling_window_hash.sv */
`timescale 1ns / 1ps
// rolling window hash: top level joining the sequencer and the datapath
//
// Rabin-Karp rolling hash over a byte stream, base 101, modulus 5463458053.
// Each accepted character updates the running hash as
// ((h - oldest * 101^(k-1)) * 101 + c) mod M, and once k characters of the
// current string have been seen a transaction carries the hash of the last
// k characters and the position of that window's first character
// (saturating at POSITION_MAX, low 16 bits shown). first_of_string restarts
// the string at the character it comes with. Between one acceptance and
// the next, a character is latched while the oldest character is read
// from the window ring, then multiplied, formed into the biased sum,
// reduced digit by digit in radix-4 by the shared modular reducer and
// written back; while an earlier result still waits, the next character
// holds at write-back until that result is taken. The result register lets
// the next character be taken while a finished hash waits. A window length
// write recomputes 101^(k-1) with the same reducer; meanwhile neither
// channel is ready. Window sizes of zero and above WINDOW_MAX are clamped
// to 1 and WINDOW_MAX. The window ring has no reset; it is only read at
// entries written in the current string.
module rolling_window_hash #(
  parameter int unsigned WINDOW_MAX   = rwh_pkg::WINDOW_MAX_DEF,
  parameter int unsigned POSITION_MAX = rwh_pkg::POSITION_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // character transactions
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rwh_pkg::rwh_in_t          in_data_i,
  // hash transactions
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rwh_pkg::rwh_out_t         out_data_o,
  // window length register write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rwh_pkg::WS_W-1:0]  cfg_data_i
);
  import rwh_pkg::*;

  rwh_cmd_t    cmd;
  rwh_status_t status;

  // sequencer: handshakes, digit count, result valid
  rwh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath: ring, hash, counters and modular reducer
  rwh_datapath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .POSITION_MAX (POSITION_MAX)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

/* hw/rtl/rwh_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module rwh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rwh_ctrl.sv */
`timescale 1ns / 1ps
// sequencer for the rolling window hash: handshakes and datapath commands
module rwh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  output rwh_pkg::rwh_cmd_t     cmd_o,
  input  rwh_pkg::rwh_status_t  status_i
);
  import rwh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RED,
    ST_UPD,
    ST_PCHK,
    ST_PMUL,
    ST_PRED,
    ST_PWB
  } state_e;

  state_e             state_q, state_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !in_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    digit_d     = digit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NOP;
    cmd_o.digit = digit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_MUL;
        end else if (cfg_valid_i) begin
          cmd_o.op = OP_CFG;
          state_d  = ST_PCHK;
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        digit_d  = DIGIT_W'(DIGITS - 1);
        state_d  = ST_RED;
      end
      ST_RED: begin
        cmd_o.op = OP_REDUCE;
        if (digit_q == '0) begin
          state_d = ST_UPD;
        end else begin
          digit_d = digit_q - DIGIT_W'(1);
        end
      end
      ST_UPD: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_UPDATE;
          out_valid_d = status_i.emit;
          state_d     = ST_IDLE;
        end
      end
      ST_PCHK: begin
        state_d = status_i.pow_done ? ST_IDLE : ST_PMUL;
      end
      ST_PMUL: begin
        cmd_o.op = OP_POW;
        digit_d  = DIGIT_W'(DIGITS - 1);
        state_d  = ST_PRED;
      end
      ST_PRED: begin
        cmd_o.op = OP_REDUCE;
        if (digit_q == '0) begin
          state_d = ST_PWB;
        end else begin
          digit_d = digit_q - DIGIT_W'(1);
        end
      end
      ST_PWB: begin
        cmd_o.op = OP_POW_WB;
        state_d  = status_i.pow_last ? ST_IDLE : ST_PMUL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      digit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      digit_q     <= digit_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/rwh_datapath.sv */
`timescale 1ns / 1ps
// datapath for the rolling window hash: window ring, hash state and modular reducer
module rwh_datapath #(
  parameter int unsigned WINDOW_MAX   = rwh_pkg::WINDOW_MAX_DEF,
  parameter int unsigned POSITION_MAX = rwh_pkg::POSITION_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rwh_pkg::rwh_cmd_t         cmd_i,
  output rwh_pkg::rwh_status_t      status_o,
  input  rwh_pkg::rwh_in_t          in_data_i,
  input  logic [rwh_pkg::WS_W-1:0]  cfg_data_i,
  output rwh_pkg::rwh_out_t         out_data_o
);
  import rwh_pkg::*;

  localparam int unsigned K_W       = $clog2(WINDOW_MAX + 1);
  localparam int unsigned AW        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned IW        = ((AW > K_W) ? AW : K_W) + 1;
  localparam int unsigned CMP_W     = (K_W > WS_W) ? K_W : WS_W;
  localparam int unsigned COUNT_CAP = POSITION_MAX + WINDOW_MAX;
  localparam int unsigned CNT_W     = $clog2(COUNT_CAP + 1);
  localparam int unsigned RESET_K   =
      (32'(RESET_WINDOW) > WINDOW_MAX) ? WINDOW_MAX : 32'(RESET_WINDOW);
  localparam logic [PW_W-1:0] RESET_PW =
      PW_W'(base_power(RESET_K - 1)) * PW_W'(HASH_BASE);

  // control state
  logic [K_W-1:0]    k_q, k_d;
  logic [PW_W-1:0]   pw_q, pw_d;          // base * drop power, kept unreduced
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [K_W-1:0]    pow_left_q, pow_left_d;

  // payload
  logic [CHAR_W-1:0] char_q, char_d;
  logic [ACC_W-1:0]  prod_q, prod_d;
  logic [PW_W-1:0]   hsum_q, hsum_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  rwh_out_t          out_q, out_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic [CMP_W-1:0]  ws_ext;
  logic [K_W-1:0]    cfg_k;
  logic [CNT_W-1:0]  k_cnt, count_next, start, start_sat;
  logic              drop, emit;
  logic [IW-1:0]     ptr_ext, k_ext, rd_idx;
  logic [AW-1:0]     ptr_next;
  logic [CHAR_W-1:0] drop_char;
  logic [ACC_W-1:0]  m1, m2, m3, reduced;
  logic [ACC_W:0]    sub1, sub2, sub3;

  rwh_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (char_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    // window size clamped to 1..WINDOW_MAX
    ws_ext = CMP_W'(cfg_data_i);
    if (ws_ext == '0) begin
      cfg_k = K_W'(1);
    end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
      cfg_k = K_W'(WINDOW_MAX);
    end else begin
      cfg_k = K_W'(ws_ext);
    end

    // oldest character of the window sits k places behind the write pointer
    ptr_ext = IW'(wr_ptr_q);
    k_ext   = IW'(k_q);
    if (ptr_ext >= k_ext) begin
      rd_idx = ptr_ext - k_ext;
    end else begin
      rd_idx = ptr_ext + IW'(WINDOW_MAX) - k_ext;
    end
    ram_raddr = AW'(rd_idx);
    ptr_next  = (wr_ptr_q == AW'(WINDOW_MAX - 1)) ? '0 : wr_ptr_q + AW'(1);

    k_cnt      = CNT_W'(k_q);
    drop       = (count_q >= k_cnt);
    count_next = (count_q < CNT_W'(COUNT_CAP)) ? count_q + CNT_W'(1) : count_q;
    emit       = (count_next >= k_cnt);
    start      = count_next - k_cnt;
    start_sat  = (start > CNT_W'(POSITION_MAX)) ? CNT_W'(POSITION_MAX) : start;

    drop_char = drop ? ram_rdata : '0;

    // radix-4 digit: subtract the largest of 1, 2, 3 times modulus * 4^digit
    m1 = '0;
    m2 = '0;
    m3 = '0;
    for (int unsigned j = 0; j < DIGITS; j++) begin
      if (cmd_i.digit == DIGIT_W'(j)) begin
        m1 = mod_multiple(1, j);
        m2 = mod_multiple(2, j);
        m3 = mod_multiple(3, j);
      end
    end
    sub1 = {1'b0, acc_q} - {1'b0, m1};
    sub2 = {1'b0, acc_q} - {1'b0, m2};
    sub3 = {1'b0, acc_q} - {1'b0, m3};
    if (!sub3[ACC_W]) begin
      reduced = sub3[ACC_W-1:0];
    end else if (!sub2[ACC_W]) begin
      reduced = sub2[ACC_W-1:0];
    end else if (!sub1[ACC_W]) begin
      reduced = sub1[ACC_W-1:0];
    end else begin
      reduced = acc_q;
    end

    k_d        = k_q;
    pw_d       = pw_q;
    hash_d     = hash_q;
    count_d    = count_q;
    wr_ptr_d   = wr_ptr_q;
    pow_left_d = pow_left_q;
    char_d     = char_q;
    prod_d     = prod_q;
    hsum_d     = hsum_q;
    acc_d      = acc_q;
    out_d      = out_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    unique case (cmd_i.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        char_d = in_data_i.char_in;
        ram_re = 1'b1;
        if (in_data_i.first_of_string) begin
          hash_d  = '0;
          count_d = '0;
        end
      end
      OP_MUL: begin
        prod_d = ACC_W'(drop_char) * ACC_W'(pw_q);
        hsum_d = PW_W'(hash_q) * PW_W'(HASH_BASE) + PW_W'(char_q);
      end
      OP_SUM: begin
        acc_d = DROP_OFFSET + ACC_W'(hsum_q) - prod_q;
      end
      OP_REDUCE: begin
        acc_d = reduced;
      end
      OP_UPDATE: begin
        hash_d   = acc_q[HASH_W-1:0];
        ram_we   = 1'b1;
        wr_ptr_d = ptr_next;
        count_d  = count_next;
        if (emit) begin
          out_d.hash_value   = acc_q[HASH_W-1:0];
          out_d.window_start = POS_W'(start_sat);
        end
      end
      OP_CFG: begin
        k_d        = cfg_k;
        pw_d       = PW_W'(HASH_BASE);
        pow_left_d = cfg_k - K_W'(1);
      end
      OP_POW: begin
        acc_d = ACC_W'(pw_q);
      end
      OP_POW_WB: begin
        pw_d       = PW_W'(acc_q[HASH_W-1:0]) * PW_W'(HASH_BASE);
        pow_left_d = pow_left_q - K_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign status_o.emit     = emit;
  assign status_o.pow_done = (pow_left_q == '0);
  assign status_o.pow_last = (pow_left_q == K_W'(1));
  assign out_data_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= K_W'(RESET_K);
      pw_q       <= RESET_PW;
      hash_q     <= '0;
      count_q    <= '0;
      wr_ptr_q   <= '0;
      pow_left_q <= '0;
    end else begin
      k_q        <= k_d;
      pw_q       <= pw_d;
      hash_q     <= hash_d;
      count_q    <= count_d;
      wr_ptr_q   <= wr_ptr_d;
      pow_left_q <= pow_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    prod_q <= prod_d;
    hsum_q <= hsum_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

endmodule

/* hw/rtl/rwh_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the rolling window hash and their binding
module rwh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rwh_pkg::rwh_out_t  out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);

  logic in_acc, cfg_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  // a character and a register write never complete together
  a_no_dual_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && cfg_acc))
    else $error("character and register write accepted together");

  // one character in flight at a time
  a_busy_after_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o && !cfg_ready_o)
    else $error("ready again right after a character transaction");

  // power recomputation blocks characters
  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> !in_ready_o && !cfg_ready_o)
    else $error("ready again right after a register write");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled hash transaction changed or dropped");

endmodule

bind rolling_window_hash rwh_checker u_rwh_checker (.*);
